### rtl/spectrum_log_bar_column_top_defines.svh
// Assertion macros shared by the spectrum bar column RTL.
`ifndef SPECTRUM_LOG_BAR_COLUMN_TOP_DEFINES_SVH
`define SPECTRUM_LOG_BAR_COLUMN_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define SLBC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slbc same-cycle check failed");
`define SLBC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slbc next-cycle check failed");
`else
`define SLBC_ASSERT_IMPL(lbl, ante, cons)
`define SLBC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### rtl/slbc_pkg.sv
// Shared constants and types of the spectrum bar column block.
`default_nettype none

package slbc_pkg;

  localparam int FFT_BINS_DEF        = 512;
  localparam int DISPLAY_COLUMNS_DEF = 384;

  localparam int MAG_W     = 32;
  localparam int SQ_W      = 2 * MAG_W;
  localparam int MANT_W    = 32;
  localparam int PROD_W    = 2 * MANT_W;
  localparam int EXP_W     = 6;
  localparam int FRAC_BITS = 6;
  localparam int Y_W       = EXP_W + FRAC_BITS;

  // floor((2126 - y) / 30) = floor((y_bias - y) / 30) - Q_BIAS, y_bias = 2126 + 30*Q_BIAS
  localparam int U_W         = 13;
  localparam int LOG_BIAS    = 4106;
  localparam int Q_BIAS      = 66;
  localparam int RECIP       = 2185;
  localparam int RECIP_W     = 12;
  localparam int RECIP_SHIFT = 16;
  localparam int Q_W         = 8;
  localparam int N_W         = 10;

  localparam int MASK_W       = 32;
  localparam int RETICLE_BITS = 4;
  localparam int NUM_RETICLE  = 8;
  localparam int RETICLE_OFFSETS [NUM_RETICLE] = '{0, 26, 51, 77, 102, 128, 154, 179};

  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 16;

  localparam int OFFSET_W   = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;

  localparam logic [OFFSET_W-1:0] OFFSET_RESET  = 6'd24;
  localparam logic                RETICLE_RESET = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OFFSET_PIXELS  = 1'b0,
    CFG_RETICLE_ENABLE = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] offset_pixels;
    logic                reticle_enable;
  } cfg_t;

endpackage

`default_nettype wire

### rtl/slbc_fifo.sv
// Small register queue with first-word-fall-through read.
`default_nettype none

`include "spectrum_log_bar_column_top_defines.svh"

module slbc_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] wdata,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      rdata,
  output logic              empty
);

  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    count_nxt = count_r + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  `SLBC_ASSERT_IMPL(a_no_push_when_full, push, !full)
  `SLBC_ASSERT_IMPL(a_no_pop_when_empty, pop, !empty)
  `SLBC_ASSERT_NEXT(a_push_fills, push && !pop, !empty)

endmodule

`default_nettype wire

### rtl/slbc_front.sv
// Front end: takes bins, drops the hidden band, maps columns and reticle, takes magnitudes.
`default_nettype none

module slbc_front #(
  parameter int FFT_BINS        = slbc_pkg::FFT_BINS_DEF,
  parameter int DISPLAY_COLUMNS = slbc_pkg::DISPLAY_COLUMNS_DEF
) (
  input  wire logic                                         clk,
  input  wire logic                                         rst_n,
  input  wire slbc_pkg::cfg_t                               cfg,
  input  wire logic                                         in_push,
  output logic                                              in_full,
  input  wire logic [$clog2(FFT_BINS)-1:0]                  in_bin_index,
  input  wire logic signed [slbc_pkg::MAG_W-1:0]            in_real_part,
  input  wire logic signed [slbc_pkg::MAG_W-1:0]            in_imag_part,
  output logic                                              mid_push,
  output logic [$clog2(DISPLAY_COLUMNS)+2*slbc_pkg::MAG_W:0] mid_wdata,
  input  wire logic                                         mid_full
);

  localparam int BW        = $clog2(FFT_BINS);
  localparam int CW        = $clog2(DISPLAY_COLUMNS);
  localparam int EW        = ((BW > CW) ? BW : CW) + 1;
  localparam int HALF      = DISPLAY_COLUMNS / 2;
  localparam bit HAS_HIGH  = (FFT_BINS >= HALF);
  localparam int HIGH_BASE = HAS_HIGH ? (FFT_BINS - HALF) : 0;
  localparam int MW        = slbc_pkg::MAG_W;

  function automatic logic [MW-1:0] mag_of(input logic signed [MW-1:0] v);
    logic [MW-1:0] m;
    m = v[MW-1] ? (~v + MW'(1)) : v;
    return m;
  endfunction

  logic [EW-1:0] bin_ext, col_ext;
  logic          in_range, low_bin, high_bin, keep, hit, accept;

  logic          fv_r, fv_nxt;
  logic [CW-1:0] col_r;
  logic          ret_r;
  logic [MW-1:0] mag_a_r, mag_b_r;

  always_comb begin
    bin_ext  = EW'(in_bin_index);
    in_range = bin_ext < EW'(FFT_BINS);
    low_bin  = bin_ext < EW'(HALF);
    high_bin = HAS_HIGH && (bin_ext >= EW'(HIGH_BASE));
    keep     = in_range && (low_bin || high_bin);
    col_ext  = low_bin ? (bin_ext + EW'(HALF)) : (bin_ext - EW'(HIGH_BASE));
    hit      = 1'b0;
    for (int i = 0; i < slbc_pkg::NUM_RETICLE; i++) begin
      if ((HALF + slbc_pkg::RETICLE_OFFSETS[i] < DISPLAY_COLUMNS) &&
          (col_ext == EW'(HALF + slbc_pkg::RETICLE_OFFSETS[i]))) begin
        hit = 1'b1;
      end
      if ((slbc_pkg::RETICLE_OFFSETS[i] <= HALF) &&
          (col_ext == EW'(HALF - slbc_pkg::RETICLE_OFFSETS[i]))) begin
        hit = 1'b1;
      end
    end
  end

  assign in_full   = fv_r && mid_full;
  assign accept    = in_push && !in_full;
  assign mid_push  = fv_r && !mid_full;
  assign mid_wdata = {col_r, ret_r, mag_a_r, mag_b_r};

  always_comb begin
    fv_nxt = fv_r;
    if (mid_push) begin
      fv_nxt = 1'b0;
    end
    if (accept && keep) begin
      fv_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else begin
      fv_r <= fv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && keep) begin
      col_r   <= col_ext[CW-1:0];
      ret_r   <= hit && cfg.reticle_enable;
      mag_a_r <= mag_of(in_real_part);
      mag_b_r <= mag_of(in_imag_part);
    end
  end

endmodule

`default_nettype wire

### rtl/slbc_back.sv
// Back end: power, log2 by repeated squaring, bar height, mask and result queue.
`default_nettype none

`include "spectrum_log_bar_column_top_defines.svh"

module slbc_back #(
  parameter int DISPLAY_COLUMNS = slbc_pkg::DISPLAY_COLUMNS_DEF
) (
  input  wire logic                                          clk,
  input  wire logic                                          rst_n,
  input  wire slbc_pkg::cfg_t                                cfg,
  input  wire logic [$clog2(DISPLAY_COLUMNS)+2*slbc_pkg::MAG_W:0] mid_rdata,
  input  wire logic                                          mid_empty,
  output logic                                               mid_pop,
  output logic                                               out_empty,
  input  wire logic                                          out_pop,
  output logic [$clog2(DISPLAY_COLUMNS)-1:0]                 out_column_index,
  output logic [slbc_pkg::MASK_W-1:0]                        out_column_mask
);

  localparam int CW      = $clog2(DISPLAY_COLUMNS);
  localparam int SIDE_W  = CW + 1;
  localparam int MW      = slbc_pkg::MAG_W;
  localparam int SW      = slbc_pkg::SQ_W;
  localparam int NW      = slbc_pkg::MANT_W;
  localparam int PW      = slbc_pkg::PROD_W;
  localparam int XW      = slbc_pkg::EXP_W;
  localparam int FB      = slbc_pkg::FRAC_BITS;
  localparam int UW      = slbc_pkg::U_W;
  localparam int RW      = slbc_pkg::RECIP_W;
  localparam int QW      = slbc_pkg::Q_W;
  localparam int NN      = slbc_pkg::N_W;
  localparam int KW      = slbc_pkg::MASK_W;
  localparam int SH_W    = $clog2(KW);
  localparam int OCC_W   = $clog2(slbc_pkg::OUT_DEPTH + 1);
  localparam int OUT_W   = CW + KW;

  logic              take, opop;
  logic [SIDE_W-1:0] side_in;
  logic [MW-1:0]     mag_a, mag_b;
  logic [OCC_W-1:0]  occ_r, occ_nxt;

  // power
  logic              s1_v_r;
  logic [SIDE_W-1:0] s1_side_r;
  logic [SW-1:0]     s1_sqa_r, s1_sqb_r;
  logic              s2_v_r;
  logic [SIDE_W-1:0] s2_side_r;
  logic [SW-1:0]     s2_sum_r;
  // coarse normalize
  logic              s3_v_r, s3_zero_r;
  logic [SIDE_W-1:0] s3_side_r;
  logic [SW-1:0]     s3_norm_r;
  logic [1:0]        s3_crs_r;
  logic [1:0]        crs;
  logic [SW-1:0]     norm1;
  // fine normalize and squaring chain
  logic              lg_v_r    [FB+1];
  logic              lg_zero_r [FB+1];
  logic [SIDE_W-1:0] lg_side_r [FB+1];
  logic [XW-1:0]     lg_exp_r  [FB+1];
  logic [NW-1:0]     lg_mant_r [FB+1];
  logic [FB-1:0]     lg_frac_r [FB+1];
  logic [3:0]        lz;
  logic [SW-1:0]     norm2;
  logic [PW-1:0]     sq_prod   [FB];
  logic [NW-1:0]     mant_nx   [FB];
  // height
  logic              fq_v_r, fq_zero_r;
  logic [SIDE_W-1:0] fq_side_r;
  logic [QW-1:0]     fq_q_r;
  logic [slbc_pkg::Y_W-1:0] y;
  logic [UW-1:0]     u;
  logic [UW+RW-1:0]  qprod;
  logic [NN-1:0]     n;
  logic [KW-1:0]     mask;
  logic [CW-1:0]     fq_col;
  logic              fq_ret;

  logic [OUT_W-1:0]  ofifo_rdata;
  logic              ofifo_full;

  assign {side_in, mag_a, mag_b} = mid_rdata;
  assign take    = !mid_empty && (occ_r < OCC_W'(slbc_pkg::OUT_DEPTH));
  assign mid_pop = take;
  assign opop    = out_pop && !out_empty;
  assign occ_nxt = occ_r + OCC_W'(take) - OCC_W'(opop);

  always_comb begin
    if (s2_sum_r[63:48] != '0) begin
      crs = 2'd0;
    end else if (s2_sum_r[47:32] != '0) begin
      crs = 2'd1;
    end else if (s2_sum_r[31:16] != '0) begin
      crs = 2'd2;
    end else begin
      crs = 2'd3;
    end
    norm1 = s2_sum_r << {crs, 4'b0000};
  end

  always_comb begin
    lz = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (s3_norm_r[48 + i]) begin
        lz = 4'(15 - i);
      end
    end
    norm2 = s3_norm_r << lz;
  end

  always_comb begin
    for (int k = 0; k < FB; k++) begin
      sq_prod[k] = PW'(lg_mant_r[k]) * PW'(lg_mant_r[k]);
      mant_nx[k] = sq_prod[k][PW-1] ? sq_prod[k][PW-1 -: NW] : sq_prod[k][PW-2 -: NW];
    end
  end

  always_comb begin
    y     = {lg_exp_r[FB], lg_frac_r[FB]};
    u     = UW'(slbc_pkg::LOG_BIAS) - UW'(y);
    qprod = (UW + RW)'(u) * (UW + RW)'(slbc_pkg::RECIP);
  end

  assign {fq_col, fq_ret} = fq_side_r;

  always_comb begin
    n = NN'(cfg.offset_pixels) + NN'(fq_q_r) - NN'(slbc_pkg::Q_BIAS);
    if (fq_zero_r) begin
      mask = '0;
    end else if (n[NN-1]) begin
      mask = '1;
    end else if (n >= NN'(KW)) begin
      mask = '0;
    end else begin
      mask = {KW{1'b1}} << n[SH_W-1:0];
    end
    if (fq_ret) begin
      mask[slbc_pkg::RETICLE_BITS-1:0] = '1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r  <= '0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      fq_v_r <= 1'b0;
      for (int k = 0; k <= FB; k++) begin
        lg_v_r[k] <= 1'b0;
      end
    end else begin
      occ_r     <= occ_nxt;
      s1_v_r    <= take;
      s2_v_r    <= s1_v_r;
      s3_v_r    <= s2_v_r;
      lg_v_r[0] <= s3_v_r;
      for (int k = 0; k < FB; k++) begin
        lg_v_r[k+1] <= lg_v_r[k];
      end
      fq_v_r <= lg_v_r[FB];
    end
  end

  always_ff @(posedge clk) begin
    s1_side_r <= side_in;
    s1_sqa_r  <= SW'(mag_a) * SW'(mag_a);
    s1_sqb_r  <= SW'(mag_b) * SW'(mag_b);

    s2_side_r <= s1_side_r;
    s2_sum_r  <= s1_sqa_r + s1_sqb_r;

    s3_side_r <= s2_side_r;
    s3_zero_r <= (s2_sum_r == '0);
    s3_norm_r <= norm1;
    s3_crs_r  <= crs;

    lg_side_r[0] <= s3_side_r;
    lg_zero_r[0] <= s3_zero_r;
    lg_exp_r[0]  <= XW'(SW - 1) - {s3_crs_r, lz};
    lg_mant_r[0] <= norm2[SW-1 -: NW];
    lg_frac_r[0] <= '0;
    for (int k = 0; k < FB; k++) begin
      lg_side_r[k+1] <= lg_side_r[k];
      lg_zero_r[k+1] <= lg_zero_r[k];
      lg_exp_r[k+1]  <= lg_exp_r[k];
      lg_mant_r[k+1] <= mant_nx[k];
      lg_frac_r[k+1] <= {lg_frac_r[k][FB-2:0], sq_prod[k][PW-1]};
    end

    fq_side_r <= lg_side_r[FB];
    fq_zero_r <= lg_zero_r[FB];
    fq_q_r    <= qprod[slbc_pkg::RECIP_SHIFT +: QW];
  end

  slbc_fifo #(
    .W     (OUT_W),
    .DEPTH (slbc_pkg::OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fq_v_r),
    .wdata ({fq_col, mask}),
    .full  (ofifo_full),
    .pop   (opop),
    .rdata (ofifo_rdata),
    .empty (out_empty)
  );

  assign {out_column_index, out_column_mask} = ofifo_rdata;

  `SLBC_ASSERT_IMPL(a_result_has_room, fq_v_r, !ofifo_full)
  `SLBC_ASSERT_IMPL(a_credit_bound, 1'b1, occ_r <= OCC_W'(slbc_pkg::OUT_DEPTH))
  `SLBC_ASSERT_IMPL(a_no_credit_no_result, occ_r == '0, out_empty && !fq_v_r)

endmodule

`default_nettype wire

### rtl/spectrum_log_bar_column_top.sv
// Top level of the log-magnitude spectrum bar column generator.
//
//  channel  | handshake              | beat
//  ---------+------------------------+---------------------------------------------
//  input    | in_push / in_full      | in_bin_index, in_real_part, in_imag_part
//  result   | out_pop / out_empty    | out_column_index, out_column_mask
//  config   | cfg_we                 | cfg_index, cfg_wdata
//
// One bin per clock sustained unless in_full holds the input; bins in the hidden band take no result slot.
// Path from input beat to result: front register, middle queue, two power stages,
// two normalize steps, six squaring stages, height multiply, result queue.
// The 4-deep middle queue and 16-deep result queue let input and output stall apart;
// the back end issues only while result credit remains.
// Synchronous active-low reset clears queues, pipeline valids and config to defaults.
`default_nettype none

module spectrum_log_bar_column_top #(
  parameter int FFT_BINS        = slbc_pkg::FFT_BINS_DEF,
  parameter int DISPLAY_COLUMNS = slbc_pkg::DISPLAY_COLUMNS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [slbc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [slbc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  wire logic                                in_push,
  output logic                                     in_full,
  input  wire logic [$clog2(FFT_BINS)-1:0]         in_bin_index,
  input  wire logic signed [slbc_pkg::MAG_W-1:0]   in_real_part,
  input  wire logic signed [slbc_pkg::MAG_W-1:0]   in_imag_part,
  output logic                                     out_empty,
  input  wire logic                                out_pop,
  output logic [$clog2(DISPLAY_COLUMNS)-1:0]       out_column_index,
  output logic [slbc_pkg::MASK_W-1:0]              out_column_mask
);

  localparam int ENT_W = $clog2(DISPLAY_COLUMNS) + 1 + 2 * slbc_pkg::MAG_W;

  slbc_pkg::cfg_t cfg_r, cfg_nxt;

  logic             mid_push, mid_full, mid_pop, mid_empty;
  logic [ENT_W-1:0] mid_wdata, mid_rdata;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (slbc_pkg::cfg_reg_t'(cfg_index))
        slbc_pkg::CFG_OFFSET_PIXELS: begin
          cfg_nxt.offset_pixels = cfg_wdata[slbc_pkg::OFFSET_W-1:0];
        end
        slbc_pkg::CFG_RETICLE_ENABLE: begin
          cfg_nxt.reticle_enable = cfg_wdata[0];
        end
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.offset_pixels  <= slbc_pkg::OFFSET_RESET;
      cfg_r.reticle_enable <= slbc_pkg::RETICLE_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  slbc_front #(
    .FFT_BINS        (FFT_BINS),
    .DISPLAY_COLUMNS (DISPLAY_COLUMNS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_bin_index (in_bin_index),
    .in_real_part (in_real_part),
    .in_imag_part (in_imag_part),
    .mid_push     (mid_push),
    .mid_wdata    (mid_wdata),
    .mid_full     (mid_full)
  );

  slbc_fifo #(
    .W     (ENT_W),
    .DEPTH (slbc_pkg::MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mid_push),
    .wdata (mid_wdata),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .empty (mid_empty)
  );

  slbc_back #(
    .DISPLAY_COLUMNS (DISPLAY_COLUMNS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .mid_rdata        (mid_rdata),
    .mid_empty        (mid_empty),
    .mid_pop          (mid_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_column_index (out_column_index),
    .out_column_mask  (out_column_mask)
  );

endmodule

`default_nettype wire

### verif/tb_spectrum_log_bar_column_top.sv
// Testbench for spectrum_log_bar_column_top: random and directed bins checked against a scoreboard.
`timescale 1ns / 1ps

module tb_spectrum_log_bar_column_top;

  typedef struct {
    logic [8:0]  col;
    logic [31:0] mask;
  } column_beat_t;

  class bar_scoreboard;
    logic [5:0]   offset_px;
    bit           reticle_on;
    column_beat_t pending_columns[$];
    int           errors;
    int           checked;

    function new();
      offset_px  = 6'd24;
      reticle_on = 1'b1;
    endfunction

    function void set_reg(slbc_pkg::cfg_reg_t idx, logic [5:0] v);
      if (idx == slbc_pkg::CFG_OFFSET_PIXELS) offset_px = v;
      else reticle_on = v[0];
    endfunction

    function int pending();
      return pending_columns.size();
    endfunction

    // floor(64 * log2(s)) by repeated squaring of the normalized mantissa
    function int log2_q6(logic [63:0] s);
      int p;
      int frac;
      logic [63:0] mant;
      p = 0;
      frac = 0;
      for (int i = 0; i < 64; i++)
        if (s[i]) p = i;
      if (p >= 31) mant = s >> (p - 31);
      else mant = s << (31 - p);
      for (int i = 0; i < 6; i++) begin
        mant = (mant * mant) >> 31;
        frac = frac << 1;
        if (mant >= 64'h1_0000_0000) begin
          frac = frac | 1;
          mant = mant >> 1;
        end
      end
      return p * 64 + frac;
    endfunction

    function logic [31:0] height_mask(logic [63:0] s);
      int t;
      int m;
      int n;
      if (s == 64'd0) return 32'd0;
      t = 2126 - log2_q6(s);
      if (t >= 0) m = t / 30;
      else m = -((-t + 29) / 30);
      n = int'(offset_px) + m;
      if (n >= 32) return 32'd0;
      if (n < 0) return 32'hFFFF_FFFF;
      return ~((32'd1 << n) - 32'd1);
    endfunction

    function bit on_reticle(int col);
      int offs[8];
      offs = '{0, 26, 51, 77, 102, 128, 154, 179};
      foreach (offs[i])
        if ((192 + offs[i] < 384 && col == 192 + offs[i]) || col == 192 - offs[i]) return 1'b1;
      return 1'b0;
    endfunction

    function logic [63:0] magnitude(logic [31:0] v);
      logic [63:0] a;
      a = v[31] ? (64'h1_0000_0000 - {32'd0, v}) : {32'd0, v};
      return a * a;
    endfunction

    // returns 1 when the bin lands on a display column
    function bit note_bin(logic [8:0] bin, logic [31:0] re, logic [31:0] im);
      column_beat_t c;
      int col;
      if (bin < 192) col = bin + 192;
      else if (bin >= 320) col = bin - 320;
      else return 1'b0;
      c.col  = col[8:0];
      c.mask = height_mask(magnitude(re) + magnitude(im));
      if (reticle_on && on_reticle(col)) c.mask = c.mask | 32'hF;
      pending_columns.push_back(c);
      return 1'b1;
    endfunction

    function void check_column(logic [8:0] col, logic [31:0] mask);
      column_beat_t c;
      if (pending_columns.size() == 0) begin
        $error("column_index: no column expected, got %0d", col);
        errors++;
        return;
      end
      c = pending_columns.pop_front();
      checked++;
      if (col !== c.col) begin
        $error("column_index: expected %0d, got %0d", c.col, col);
        errors++;
      end
      if (mask !== c.mask) begin
        $error("column_mask: expected %08h, got %08h", c.mask, mask);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [slbc_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [slbc_pkg::CFG_DATA_W-1:0] cfg_wdata;
  logic        in_push;
  logic        in_full;
  logic [8:0]  in_bin_index;
  logic [31:0] in_real_part;
  logic [31:0] in_imag_part;
  logic        out_empty;
  logic        out_pop;
  logic [8:0]  out_column_index;
  logic [31:0] out_column_mask;

  bar_scoreboard sb = new();
  bit tx_quiet;
  int bins_sent;
  int bins_dropped;

  spectrum_log_bar_column_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_bin_index     (in_bin_index),
    .in_real_part     (in_real_part),
    .in_imag_part     (in_imag_part),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_column_index (out_column_index),
    .out_column_mask  (out_column_mask)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("tb_spectrum_log_bar_column_top: done, errors");
    $finish;
  end

  function automatic int pick_gap(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] rand_part();
    logic [31:0] v;
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'd0;
    if (r == 1) begin
      case ($urandom_range(0, 3))
        0: return 32'h8000_0000;
        1: return 32'h7FFF_FFFF;
        2: return 32'hFFFF_FFFF;
        default: return 32'd1;
      endcase
    end
    v = $urandom;
    if (r > 3) v = v >> $urandom_range(0, 31);
    if ($urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  function automatic logic [8:0] rand_bin();
    int r;
    int offs[8];
    int col;
    offs = '{0, 26, 51, 77, 102, 128, 154, 179};
    r = $urandom_range(0, 99);
    if (r < 20) return 9'($urandom_range(192, 319));
    if (r < 30) begin
      col = 192 + ($urandom_range(0, 1) ? offs[$urandom_range(0, 7)] : -offs[$urandom_range(0, 7)]);
      return (col >= 192) ? 9'(col - 192) : 9'(col + 320);
    end
    if (r < 65) return 9'($urandom_range(0, 191));
    return 9'($urandom_range(320, 511));
  endfunction

  task automatic send_bin(logic [8:0] bin, logic [31:0] re, logic [31:0] im);
    int gap;
    if ($urandom_range(0, 49) == 0) tx_quiet = !tx_quiet;
    gap = pick_gap(tx_quiet);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push      <= 1'b1;
    in_bin_index <= bin;
    in_real_part <= re;
    in_imag_part <= im;
    do @(posedge clk); while (in_full);
    bins_sent++;
    if (!sb.note_bin(bin, re, im)) bins_dropped++;
  endtask

  // hold input until every column is back, then let dropped bins flush out
  task automatic settle();
    in_push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(slbc_pkg::cfg_reg_t idx, logic [5:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, v);
    @(posedge clk);
  endtask

  initial begin
    int phase_offset[6];
    bit phase_reticle[6];
    int kept;
    logic [8:0] bin;
    phase_offset  = '{0, 32, 63, 16, 31, 24};
    phase_reticle = '{0, 1, 1, 0, 1, 1};
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_index    <= slbc_pkg::CFG_OFFSET_PIXELS;
    cfg_wdata    <= '0;
    in_push      <= 1'b0;
    in_bin_index <= '0;
    in_real_part <= '0;
    in_imag_part <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset config, band edges, reticle columns, magnitude extremes
    send_bin(9'd0, 32'd0, 32'd0);
    send_bin(9'd191, 32'h7FFF_FFFF, 32'd0);
    send_bin(9'd192, 32'h1234_5678, 32'h8765_4321);
    send_bin(9'd319, 32'hFFFF_FFFF, 32'h0000_0001);
    send_bin(9'd320, 32'd1, 32'd0);
    send_bin(9'd511, 32'h8000_0000, 32'h8000_0000);
    send_bin(9'd333, 32'd24460, 32'd0);
    send_bin(9'd1, 32'd24460, 32'd0);
    send_bin(9'd2, 32'd27554, 32'd0);
    send_bin(9'd3, 32'hFFFF_FFFF, 32'd0);
    send_bin(9'd4, 32'h0001_0000, 32'h0001_0000);
    send_bin(9'd5, 32'd4500000, 32'd0);
    send_bin(9'd100, 32'd0, 32'h8000_0000);
    send_bin(9'd384, 32'hFFFF_0000, 32'd300);
    send_bin(9'd179, 32'd77, 32'hFFFF_FF00);
    send_bin(9'd26, 32'h0000_8000, 32'd0);
    send_bin(9'd486, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_bin(9'd255, 32'h7FFF_FFFF, 32'h8000_0000);

    foreach (phase_offset[p]) begin
      settle();
      write_reg(slbc_pkg::CFG_OFFSET_PIXELS, 6'(phase_offset[p]));
      write_reg(slbc_pkg::CFG_RETICLE_ENABLE, 6'(phase_reticle[p]));
      send_bin(9'd0, 32'h0010_0000, 32'd0);
      send_bin(9'd383, 32'h8000_0000, 32'd5);
      kept = 0;
      while (kept < 90) begin
        bin = rand_bin();
        send_bin(bin, rand_part(), rand_part());
        if (bin < 192 || bin >= 320) kept++;
      end
    end

    settle();
    repeat (30) @(posedge clk);
    $display("bins sent %0d (%0d in the hidden band), columns checked %0d",
             bins_sent, bins_dropped, sb.checked);
    $display("offsets 0, 16, 24, 31, 32 and 63 with reticle on and off, random stalls both sides");
    if (sb.errors == 0) begin
      $display("tb_spectrum_log_bar_column_top: done, clean");
    end else begin
      $display("tb_spectrum_log_bar_column_top: done, errors");
    end
    $finish;
  end

  initial begin
    int gap;
    bit rx_quiet;
    out_pop <= 1'b0;
    repeat (7) @(posedge clk);
    forever begin
      if ($urandom_range(0, 49) == 0) rx_quiet = !rx_quiet;
      gap = pick_gap(rx_quiet);
      if (gap > 0) begin
        out_pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty);
      sb.check_column(out_column_index, out_column_mask);
    end
  end

endmodule

### sim.f
+incdir+rtl
rtl/slbc_pkg.sv
rtl/slbc_fifo.sv
rtl/slbc_front.sv
rtl/slbc_back.sv
rtl/spectrum_log_bar_column_top.sv
verif/tb_spectrum_log_bar_column_top.sv
